// ===== sv/lrw_pkg.sv =====
// ============================================================================
// lrw_pkg
// Shared codes, widths and types of the letter reachability word checker.
// ============================================================================
package lrw_pkg;

    localparam int LETTER_W = 5;
    localparam int CMD_W    = 3;
    localparam int TDATA_W  = 16;
    localparam int TUSER_W  = 4;
    localparam int OUT_W    = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAIR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd4;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_EDGE   = 3'd1;
    localparam logic [OP_W-1:0] OP_PAIR   = 3'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd3;
    localparam logic [OP_W-1:0] OP_VIA    = 3'd4;
    localparam logic [OP_W-1:0] OP_ROW    = 3'd5;

    typedef struct packed {
        logic busy;
        logic via;
    } close_req_t;

endpackage

// ===== sv/lrw_ram.sv =====
// ============================================================================
// lrw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module lrw_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/lrw_close_seq.sv =====
// ============================================================================
// lrw_close_seq
// Closure sequencer: per intermediate letter, read its row, then sweep rows.
// ============================================================================
module lrw_close_seq
    import lrw_pkg::*;
#(
    parameter int NODES = 26
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output close_req_t               req,
    output logic [$clog2(NODES)-1:0] rd_addr,
    output logic [$clog2(NODES)-1:0] k
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    logic          busy_reg, busy_next;
    logic [AW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            if (cnt_reg == CW'(NODES))
            begin
                cnt_next = '0;
                k_next   = k_reg + 1'b1;
                if (k_reg == AW'(NODES - 1))
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign req.busy = busy_reg;
    assign req.via  = (cnt_reg == '0);
    assign k        = k_reg;
    assign rd_addr  = (cnt_reg == '0) ? k_reg : AW'(cnt_reg - CW'(1));

endmodule

// ===== sv/letter_reachability_word_check_top.sv =====
// A final letter pair or finish gives its verdict through the s1 stage
// registers and then the output register. Input waits while such an item is
// in s1, while the output word is held by back-pressure and while closure runs,
// which does one row read a cycle on the single matrix RAM and writes rows back.
// Reset: matrix reads all zero through per-row valid bits, no clearing pass.
// ============================================================================
// letter_reachability_word_check_top
// Letter reachability matrix in RAM with edge add, Warshall closure and a
// word pair check that yields one verdict per word.
// ============================================================================
module letter_reachability_word_check_top
    import lrw_pkg::*;
#(
    parameter int NODES = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // from_letter[4:0], to_letter[9:5], zero
    input  logic               s_axis_tlast,   // last_pair
    input  logic [TUSER_W-1:0] s_axis_tuser,   // cmd[2:0], lengths_differ[3]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata    // verdict[0], zero
);

    localparam int AW = $clog2(NODES);

    logic                accept;
    logic [CMD_W-1:0]    cmd;
    logic [LETTER_W-1:0] from_letter;
    logic [LETTER_W-1:0] to_letter;
    logic                from_ok;
    logic                to_ok;

    close_req_t          creq;
    logic [AW-1:0]       seq_addr;
    logic [AW-1:0]       seq_k;

    logic                re;
    logic [AW-1:0]       raddr;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [NODES-1:0]    wdata;
    logic [NODES-1:0]    ram_rdata;
    logic [NODES-1:0]    row_q;

    logic [OP_W-1:0]     s1_op_reg, s1_op_next;
    logic [AW-1:0]       s1_addr_reg, s1_addr_next;
    logic [AW-1:0]       s1_bit_reg, s1_bit_next;
    logic                s1_last_reg, s1_last_next;
    logic                s1_differ_reg, s1_differ_next;
    logic                s1_eq_reg, s1_eq_next;
    logic                s1_hit_ok_reg, s1_hit_ok_next;
    logic                s1_vld_reg, s1_vld_next;
    logic                fwd_hit_reg, fwd_hit_next;
    logic [NODES-1:0]    fwd_data_reg;
    logic [NODES-1:0]    via_reg, via_next;
    logic [NODES-1:0]    valid_reg, valid_next;
    logic                word_ok_reg, word_ok_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_verdict_reg, out_verdict_next;

    logic                s1_res;
    logic                s1_res_val;
    logic                pos_ok;

    assign cmd         = s_axis_tuser[CMD_W-1:0];
    assign from_letter = s_axis_tdata[LETTER_W-1:0];
    assign to_letter   = s_axis_tdata[2*LETTER_W-1:LETTER_W];
    assign from_ok     = (32'(from_letter) < NODES);
    assign to_ok       = (32'(to_letter) < NODES);

    assign s1_res = ((s1_op_reg == OP_PAIR) && s1_last_reg) || (s1_op_reg == OP_FINISH);

    assign s_axis_tready = !creq.busy && !s1_res && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    lrw_close_seq #(
        .NODES (NODES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && (cmd == CMD_CLOSE)),
        .req     (creq),
        .rd_addr (seq_addr),
        .k       (seq_k)
    );

    lrw_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // issue stage
    always_comb
    begin
        re             = 1'b0;
        raddr          = AW'(from_letter);
        s1_op_next     = OP_NONE;
        s1_addr_next   = AW'(from_letter);
        s1_bit_next    = AW'(to_letter);
        s1_last_next   = s_axis_tlast;
        s1_differ_next = s_axis_tuser[CMD_W];
        s1_eq_next     = (from_letter == to_letter);
        s1_hit_ok_next = from_ok && to_ok;
        if (creq.busy)
        begin
            re           = 1'b1;
            raddr        = seq_addr;
            s1_addr_next = seq_addr;
            s1_bit_next  = seq_k;
            s1_op_next   = creq.via ? OP_VIA : OP_ROW;
        end
        else if (accept)
        begin
            case (cmd)
                CMD_EDGE:
                begin
                    if (from_ok && to_ok)
                    begin
                        re         = 1'b1;
                        s1_op_next = OP_EDGE;
                    end
                end
                CMD_PAIR:
                begin
                    re         = from_ok;
                    s1_op_next = OP_PAIR;
                end
                CMD_FINISH:
                begin
                    s1_op_next = OP_FINISH;
                end
                default:
                begin
                    s1_op_next = OP_NONE;
                end
            endcase
        end
    end

    // read-modify-write stage
    assign row_q  = fwd_hit_reg ? fwd_data_reg : (s1_vld_reg ? ram_rdata : '0);
    assign pos_ok = s1_eq_reg || (s1_hit_ok_reg && row_q[s1_bit_reg]);

    always_comb
    begin
        we               = 1'b0;
        waddr            = s1_addr_reg;
        wdata            = row_q | via_reg;
        via_next         = via_reg;
        word_ok_next     = word_ok_reg;
        s1_res_val       = 1'b0;
        case (s1_op_reg)
            OP_EDGE:
            begin
                we    = 1'b1;
                wdata = row_q | (NODES'(1) << s1_bit_reg);
            end
            OP_VIA:
            begin
                via_next = row_q;
            end
            OP_ROW:
            begin
                we = row_q[s1_bit_reg];
            end
            OP_PAIR:
            begin
                s1_res_val   = word_ok_reg && pos_ok;
                word_ok_next = s1_last_reg ? 1'b1 : (word_ok_reg && pos_ok);
            end
            OP_FINISH:
            begin
                s1_res_val   = !s1_differ_reg;
                word_ok_next = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase

        valid_next = valid_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
        if (accept && (cmd == CMD_CLEAR))
        begin
            valid_next = '0;
        end

        s1_vld_next  = valid_reg[raddr];
        fwd_hit_next = we && re && (waddr == raddr);

        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;
        if (s1_res)
        begin
            out_valid_next   = 1'b1;
            out_verdict_next = s1_res_val;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg     <= OP_NONE;
            fwd_hit_reg   <= 1'b0;
            valid_reg     <= '0;
            word_ok_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_op_reg     <= s1_op_next;
            fwd_hit_reg   <= fwd_hit_next;
            valid_reg     <= valid_next;
            word_ok_reg   <= word_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg     <= s1_addr_next;
        s1_bit_reg      <= s1_bit_next;
        s1_last_reg     <= s1_last_next;
        s1_differ_reg   <= s1_differ_next;
        s1_eq_reg       <= s1_eq_next;
        s1_hit_ok_reg   <= s1_hit_ok_next;
        s1_vld_reg      <= s1_vld_next;
        fwd_data_reg    <= wdata;
        via_reg         <= via_next;
        out_verdict_reg <= out_verdict_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - 1){1'b0}}, out_verdict_reg};

`ifndef SYNTH
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        creq.busy |-> !s_axis_tready)
        else $error("input taken during closure");

    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_res |=> m_axis_tvalid)
        else $error("result word lost before output register");

    a_write_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (32'(waddr) < NODES))
        else $error("matrix write outside rows");
`endif

endmodule
